[sv/pcs_pkg.sv]
// Shared types and constants for the permutation cycle sorter.
package pcs_pkg;

   localparam int NODE_W     = 5;
   localparam int CFG_W      = 6;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 6'd32;

   // Word address bit of the register file: register 0 is node_count.
   localparam logic CSR_IDX_NODE_COUNT = 1'b0;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SCAN,
      ST_WALK,
      ST_SELECT,
      ST_EMIT
   } back_state_type;

   typedef struct packed {
      logic [NODE_W-1:0] row;
      logic [NODE_W-1:0] dest;
      logic              store;
      logic              last;
   } load_entry_type;

endpackage

[sv/permutation_cycle_sorter.sv]
// Top level of the permutation cycle sorter: register port, front end, queue, cycle engine.
//
// Usage: write node_count (byte address 0) over the register port while idle, then
// send one request per matrix row on req_*; the lowest set bit of row r below
// node_count is the successor of node r. The request with req_last_row set starts
// the decomposition. Results on rsp_* list each cycle node by node, shortest cycle
// first (ties to the lower start node), closing with the start node repeated and
// rsp_cycle_end high; rsp_last_item marks the final result of a run.
// Rows: one per cycle through a two-entry queue while it has room (req_stall is high when
// it is full); rows of the next problem queue up while a run is still being emitted.
// After the last row the engine scans the nodes and walks each unvisited one around its
// cycle, recording each closed cycle; before each cycle it runs a selection scan over the
// cycle table, then sends one result per cycle from the output register unless rsp_stall
// holds it.
// Reset clears the row counter, the visited marks and the handshakes and sets
// node_count to 32; the successor and cycle tables are not cleared.
// A stalled result holds in the output register and halts emission until taken.
module permutation_cycle_sorter #(
   parameter int MAX_NODES = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [31:0]                     req_row_bits,
   input  logic                            req_last_row,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [pcs_pkg::NODE_W-1:0]      rsp_node_index,
   output logic                            rsp_cycle_end,
   output logic                            rsp_single_tour,
   output logic                            rsp_last_item,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [pcs_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [pcs_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [pcs_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import pcs_pkg::*;

   localparam int CW = $clog2(MAX_NODES + 1);
   localparam int EW = $bits(load_entry_type);

   logic [CFG_W-1:0] node_count_ff, node_count_in;
   logic [CW-1:0]    cnt;
   logic             csr_write;

   logic             q_push, q_pop, q_empty, q_full;
   load_entry_type   q_wr_entry, q_rd_entry;
   logic [EW-1:0]    q_rd_data;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_NODE_COUNT) ?
                       CSR_DATA_W'(node_count_ff) : '0;

   always_comb begin
      node_count_in = node_count_ff;
      if (csr_write && (csr_paddr[2] == CSR_IDX_NODE_COUNT)) begin
         node_count_in = csr_pwdata[CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
      end else begin
         node_count_ff <= node_count_in;
      end
   end

   // zero counts as one node, large counts saturate
   always_comb begin
      if (node_count_ff == '0) cnt = CW'(1);
      else if (node_count_ff > CFG_W'(MAX_NODES)) cnt = CW'(MAX_NODES);
      else cnt = node_count_ff[CW-1:0];
   end

   pcs_front #(
      .MAX_NODES (MAX_NODES)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .cnt          (cnt),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_row_bits (req_row_bits),
      .req_last_row (req_last_row),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_entry      (q_wr_entry)
   );

   pcs_fifo #(
      .WIDTH (EW),
      .DEPTH (2)
   ) u_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_entry),
      .pop     (q_pop),
      .rd_data (q_rd_data),
      .empty   (q_empty),
      .full    (q_full)
   );

   assign q_rd_entry = load_entry_type'(q_rd_data);

   pcs_back #(
      .MAX_NODES (MAX_NODES)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .cnt             (cnt),
      .q_empty         (q_empty),
      .q_entry         (q_rd_entry),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_node_index  (rsp_node_index),
      .rsp_cycle_end   (rsp_cycle_end),
      .rsp_single_tour (rsp_single_tour),
      .rsp_last_item   (rsp_last_item)
   );

   // the final result of a run always closes a cycle
   a_last_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_item) |-> rsp_cycle_end)
      else $error("last result does not close a cycle");

   // a single tour closes exactly once, at the end of the run
   a_single_close: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_single_tour && rsp_cycle_end) |-> rsp_last_item)
      else $error("single tour closed before the end of the run");

   // a stalled result stays valid and unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_node_index) &&
         $stable(rsp_cycle_end) && $stable(rsp_single_tour) && $stable(rsp_last_item)))
      else $error("stalled result changed");

endmodule

[sv/pcs_front.sv]
// Front end: accepts matrix rows and turns each into a successor entry.
module pcs_front #(
   parameter int MAX_NODES = 32,
   parameter int CW        = $clog2(MAX_NODES + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [CW-1:0]           cnt,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [31:0]             req_row_bits,
   input  logic                    req_last_row,
   input  logic                    q_full,
   output logic                    q_push,
   output pcs_pkg::load_entry_type q_entry
);
   import pcs_pkg::*;

   logic [CW-1:0] rows_ff;
   logic [CW-1:0] rows_in;
   logic [CW-1:0] dest;
   logic          accept;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;
   assign q_push    = accept;

   // lowest set bit below cnt, or the row's own index
   always_comb begin
      dest = rows_ff;
      for (int b = MAX_NODES - 1; b >= 0; b--) begin
         if (req_row_bits[b] && (CW'(b) < cnt)) begin
            dest = CW'(b);
         end
      end
   end

   always_comb begin
      q_entry.row   = NODE_W'(rows_ff);
      q_entry.dest  = NODE_W'(dest);
      q_entry.store = (rows_ff < CW'(MAX_NODES));
      q_entry.last  = req_last_row;
   end

   always_comb begin
      rows_in = rows_ff;
      if (accept) begin
         if (req_last_row) begin
            rows_in = '0;
         end else if (rows_ff < CW'(MAX_NODES)) begin
            rows_in = CW'(rows_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= '0;
      end else begin
         rows_ff <= rows_in;
      end
   end

endmodule

[sv/pcs_fifo.sv]
// Small request queue between the front end and the cycle engine.
module pcs_fifo #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty,
   output logic             full
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign empty   = (count_ff == '0);
   assign full    = (count_ff == NW'(DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wr_ptr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : PW'(rd_ptr_ff + 1'b1);
      end
      if (do_push && !do_pop) begin
         count_in = NW'(count_ff + 1'b1);
      end else if (do_pop && !do_push) begin
         count_in = NW'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[sv/pcs_back.sv]
// Cycle engine: successor table, cycle walk, shortest-first selection, emission.
module pcs_back #(
   parameter int MAX_NODES = 32,
   parameter int CW        = $clog2(MAX_NODES + 1),
   parameter int IW        = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [CW-1:0]               cnt,
   input  logic                        q_empty,
   input  pcs_pkg::load_entry_type     q_entry,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [pcs_pkg::NODE_W-1:0]  rsp_node_index,
   output logic                        rsp_cycle_end,
   output logic                        rsp_single_tour,
   output logic                        rsp_last_item
);
   import pcs_pkg::*;

   localparam int KW = CW + IW;   // sort key: {length, start}

   back_state_type state_ff, state_in;

   logic [IW-1:0]        succ_ff      [MAX_NODES];
   logic [IW-1:0]        start_tab_ff [MAX_NODES];
   logic [CW-1:0]        len_tab_ff   [MAX_NODES];
   logic [MAX_NODES-1:0] visited_ff;

   logic [CW-1:0] cc_ff, cc_in;
   logic [CW-1:0] k_ff, k_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic [CW-1:0] len_ff, len_in;
   logic [CW-1:0] j_ff, j_in;
   logic [CW-1:0] ec_ff, ec_in;
   logic [CW-1:0] m_ff, m_in;
   logic [KW-1:0] best_ff, best_in;
   logic [KW-1:0] prev_ff, prev_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [NODE_W-1:0] node_ff;
   logic              end_ff, single_ff, last_ff;

   logic          succ_we, cyc_we, visit_clear, visit_set, out_load;
   logic [IW-1:0] succ_rd, next_node, k_idx, j_idx, sel_start;
   logic [CW-1:0] sel_len;
   logic [KW-1:0] key_j;
   logic          out_free, closing, run_done;

   assign k_idx     = k_ff[IW-1:0];
   assign j_idx     = j_ff[IW-1:0];
   assign succ_rd   = succ_ff[cur_ff];
   // stale successors at or above the node count point back to the node
   assign next_node = (CW'(succ_rd) >= cnt) ? cur_ff : succ_rd;
   assign key_j     = {len_tab_ff[j_idx], start_tab_ff[j_idx]};
   assign sel_len   = prev_ff[KW-1:IW];
   assign sel_start = prev_ff[IW-1:0];
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign closing   = (m_ff == sel_len);
   assign run_done  = closing && (CW'(ec_ff + 1'b1) == cc_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (!q_empty && q_entry.last) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (k_ff == cnt) state_in = ST_SELECT;
            else if (!visited_ff[k_idx]) state_in = ST_WALK;
         end
         ST_WALK: begin
            if (visited_ff[cur_ff]) state_in = ST_SCAN;
         end
         ST_SELECT: begin
            if (j_ff == cc_ff) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free && closing) state_in = run_done ? ST_LOAD : ST_SELECT;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // control and datapath next values
   always_comb begin
      q_pop       = 1'b0;
      succ_we     = 1'b0;
      cyc_we      = 1'b0;
      visit_clear = 1'b0;
      visit_set   = 1'b0;
      out_load    = 1'b0;
      cc_in       = cc_ff;
      k_in        = k_ff;
      cur_in      = cur_ff;
      len_in      = len_ff;
      j_in        = j_ff;
      ec_in       = ec_ff;
      m_in        = m_ff;
      best_in     = best_ff;
      prev_in     = prev_ff;
      case (state_ff)
         ST_LOAD: begin
            q_pop = !q_empty;
            if (!q_empty) begin
               succ_we = q_entry.store;
               if (q_entry.last) begin
                  visit_clear = 1'b1;
                  cc_in       = '0;
                  k_in        = '0;
               end
            end
         end
         ST_SCAN: begin
            if (k_ff == cnt) begin
               j_in    = '0;
               best_in = '1;
               prev_in = '0;
               ec_in   = '0;
            end else if (visited_ff[k_idx]) begin
               k_in = CW'(k_ff + 1'b1);
            end else begin
               cur_in = k_idx;
               len_in = '0;
            end
         end
         ST_WALK: begin
            if (visited_ff[cur_ff]) begin
               cyc_we = 1'b1;
               cc_in  = CW'(cc_ff + 1'b1);
               k_in   = CW'(k_ff + 1'b1);
            end else begin
               visit_set = 1'b1;
               len_in    = CW'(len_ff + 1'b1);
               cur_in    = next_node;
            end
         end
         ST_SELECT: begin
            if (j_ff == cc_ff) begin
               prev_in = best_ff;
               cur_in  = best_ff[IW-1:0];
               m_in    = '0;
            end else begin
               // smallest key above the one emitted last
               if ((key_j > prev_ff) && (key_j < best_ff)) best_in = key_j;
               j_in = CW'(j_ff + 1'b1);
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_load = 1'b1;
               if (!closing) begin
                  cur_in = next_node;
                  m_in   = CW'(m_ff + 1'b1);
               end else begin
                  ec_in   = CW'(ec_ff + 1'b1);
                  j_in    = '0;
                  best_in = '1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (out_load) rsp_valid_in = 1'b1;
      else          rsp_valid_in = rsp_valid_ff && rsp_stall;
   end

   always_ff @(posedge clock) begin
      if (succ_we) begin
         succ_ff[q_entry.row[IW-1:0]] <= q_entry.dest[IW-1:0];
      end
      if (cyc_we) begin
         start_tab_ff[cc_ff[IW-1:0]] <= k_idx;
         len_tab_ff[cc_ff[IW-1:0]]   <= len_ff;
      end
      if (out_load) begin
         node_ff   <= NODE_W'(closing ? sel_start : cur_ff);
         end_ff    <= closing;
         single_ff <= (cc_ff == CW'(1));
         last_ff   <= run_done;
      end
      k_ff    <= k_in;
      cur_ff  <= cur_in;
      len_ff  <= len_in;
      j_ff    <= j_in;
      ec_ff   <= ec_in;
      m_ff    <= m_in;
      best_ff <= best_in;
      prev_ff <= prev_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         visited_ff   <= '0;
         cc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cc_ff        <= cc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (visit_clear) visited_ff <= '0;
         else if (visit_set) visited_ff[cur_ff] <= 1'b1;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_node_index  = node_ff;
   assign rsp_cycle_end   = end_ff;
   assign rsp_single_tour = single_ff;
   assign rsp_last_item   = last_ff;

endmodule

[bench/tb_top.sv]
// Self-checking bench for the permutation cycle sorter: rows in, sorted cycles out.
`timescale 1ns / 100ps

module tb_top;
   import pcs_pkg::*;

   localparam int MAX_NODES         = 32;
   localparam int BASE_ROWS         = 250;
   localparam int SETTLE_CYCLES     = 1200;   // worst walk plus selection for 32 one-node cycles
   localparam int RSP_FREEZE_CYCLES = 500;
   localparam int CYCLE_LIMIT       = 1000000;
   localparam int MAX_PRINTS        = 40;
   localparam logic [CSR_ADDR_W-1:0] NODE_COUNT_ADDR = {CSR_IDX_NODE_COUNT, 2'b00};

   typedef struct packed {
      logic [31:0] bits;
      logic        last;
   } row_req_type;

   typedef struct packed {
      logic [NODE_W-1:0] node;
      logic              closes;
      logic              one_cycle;
      logic              final_step;
   } cycle_step_type;

   typedef enum int {SHAPE_TOUR, SHAPE_PERM, SHAPE_MAP, SHAPE_SHORT, SHAPE_LONG} load_shape_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [31:0]           req_row_bits = '0;
   logic                  req_last_row = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [NODE_W-1:0]     rsp_node_index;
   logic                  rsp_cycle_end;
   logic                  rsp_single_tour;
   logic                  rsp_last_item;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // request side
   row_req_type row_q[$];
   int          rows_pushed = 0;
   int          rows_accepted = 0;
   int          problems_sent = 0;
   int          req_gap = 0;
   logic        req_fired = 1'b0;
   logic [31:0] gen_written = '0;   // successor entries written since reset
   int          gen_rows = 0;

   // response side
   cycle_step_type cycle_steps_q[$];
   int             stall_left = 0;
   logic           rsp_long_hold = 1'b0;
   logic           calm = 1'b0;
   event           freeze_rsp;

   // predictor state
   logic [NODE_W-1:0] succ_map [MAX_NODES];
   int                loaded_rows = 0;
   logic [CFG_W-1:0]  node_count_reg = NODE_COUNT_RESET;

   int          mismatches = 0;
   int          results_checked = 0;
   int unsigned bench_cycles = 0;

   permutation_cycle_sorter dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_row_bits    (req_row_bits),
      .req_last_row    (req_last_row),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_node_index  (rsp_node_index),
      .rsp_cycle_end   (rsp_cycle_end),
      .rsp_single_tour (rsp_single_tour),
      .rsp_last_item   (rsp_last_item),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
         $display("mismatch @%0d: %s", bench_cycles, msg);
   endtask

   function automatic int eff_nodes(input logic [CFG_W-1:0] value);
      if (value == 0) return 1;
      if (value > MAX_NODES) return MAX_NODES;
      return value;
   endfunction

   function automatic int next_node(input int idx, input int cnt);
      return (succ_map[idx] >= cnt) ? idx : int'(succ_map[idx]);
   endfunction

   // Store one row's successor; on the final row walk the map and queue the sorted cycles.
   task automatic load_row(input logic [31:0] row, input logic last);
      int             cnt, dest, b, k, j, m, c, cur, len, ncyc;
      logic [63:0]    in_range;
      logic [31:0]    masked;
      logic [31:0]    seen;
      int             cyc_start[MAX_NODES];
      int             cyc_len[MAX_NODES];
      int             order[MAX_NODES];
      cycle_step_type step;
      cnt = eff_nodes(node_count_reg);
      if (loaded_rows < MAX_NODES) begin
         in_range = (64'd1 << cnt) - 1;
         masked = row & in_range[31:0];
         dest = loaded_rows;
         for (b = cnt - 1; b >= 0; b--)
            if (masked[b]) dest = b;
         succ_map[loaded_rows] = NODE_W'(dest);
         loaded_rows++;
      end
      if (!last) return;

      seen = '0;
      ncyc = 0;
      for (k = 0; k < cnt; k++) begin
         if (!seen[k]) begin
            cur = k;
            len = 0;
            while (!seen[cur]) begin
               seen[cur] = 1'b1;
               len++;
               cur = next_node(cur, cnt);
            end
            cyc_start[ncyc] = k;
            cyc_len[ncyc] = len;
            ncyc++;
         end
      end

      // stable sort on length; starts are already ascending
      for (k = 0; k < ncyc; k++) begin
         j = k;
         while (j > 0 && cyc_len[order[j-1]] > cyc_len[k]) begin
            order[j] = order[j-1];
            j--;
         end
         order[j] = k;
      end

      for (k = 0; k < ncyc; k++) begin
         c = order[k];
         cur = cyc_start[c];
         for (m = 0; m <= cyc_len[c]; m++) begin
            step.closes     = (m == cyc_len[c]);
            step.node       = NODE_W'(step.closes ? cyc_start[c] : cur);
            step.one_cycle  = (ncyc == 1);
            step.final_step = step.closes && (k == ncyc - 1);
            cycle_steps_q = {cycle_steps_q, step};
            cur = next_node(cur, cnt);
         end
      end
      loaded_rows = 0;
   endtask

   // Row whose lowest set bit below cnt is target; self-pointing rows may carry no such bit.
   function automatic logic [31:0] row_for(input int target, input int self_node, input int cnt);
      logic [63:0] below_t;
      logic [63:0] in_range;
      logic [31:0] noise;
      below_t = (64'd1 << target) - 1;
      in_range = (64'd1 << cnt) - 1;
      noise = $urandom();
      if (target == self_node && $urandom_range(0, 1) == 1)
         return noise & ~in_range[31:0];
      if ($urandom_range(0, 2) == 0)
         return 32'd1 << target;
      return (noise & ~below_t[31:0]) | (32'd1 << target);
   endfunction

   task automatic queue_row(input logic [31:0] bits, input logic last);
      row_req_type r;
      r.bits = bits;
      r.last = last;
      row_q = {row_q, r};
      rows_pushed++;
      if (gen_rows < MAX_NODES) begin
         gen_written[gen_rows] = 1'b1;
         gen_rows++;
      end
      if (last) begin
         gen_rows = 0;
         problems_sent++;
      end
   endtask

   task automatic queue_problem(input load_shape_type shape);
      int cnt, nrows, i, j, tmp;
      int perm[MAX_NODES];
      int tgt[MAX_NODES];
      cnt = eff_nodes(node_count_reg);
      for (i = 0; i < cnt; i++) perm[i] = i;
      for (i = cnt - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = perm[i];
         perm[i] = perm[j];
         perm[j] = tmp;
      end
      for (i = 0; i < cnt; i++) begin
         case (shape)
            SHAPE_TOUR: tgt[perm[i]] = perm[(i + 1) % cnt];
            SHAPE_PERM: tgt[i] = perm[i];
            default:    tgt[i] = $urandom_range(0, cnt - 1);
         endcase
      end
      nrows = cnt;
      if (shape == SHAPE_SHORT) begin
         // short loads lean on older entries, which must have been written at some point
         nrows = $urandom_range(1, cnt);
         for (i = nrows; i < cnt; i++)
            if (!gen_written[i]) nrows = cnt;
      end else if (shape == SHAPE_LONG) begin
         nrows = cnt + $urandom_range(1, 3);
      end
      for (i = 0; i < nrows; i++)
         queue_row((i < cnt) ? row_for(tgt[i], i, cnt) : $urandom(), i == nrows - 1);
   endtask

   function automatic load_shape_type pick_shape();
      case ($urandom_range(0, 9))
         0, 1, 2: return SHAPE_TOUR;
         3, 4:    return SHAPE_PERM;
         5, 6:    return SHAPE_MAP;
         7:       return SHAPE_SHORT;
         8:       return SHAPE_LONG;
         default: return SHAPE_TOUR;
      endcase
   endfunction

   function automatic logic [CFG_W-1:0] pick_node_count();
      case ($urandom_range(0, 11))
         0:       return 6'd0;
         1:       return 6'd32;
         2:       return 6'd63;
         3:       return 6'd33;
         4:       return 6'd2;
         5:       return 6'd31;
         default: return CFG_W'($urandom_range(1, 10));
      endcase
   endfunction

   task automatic wait_idle();
      while (rows_accepted != rows_pushed || cycle_steps_q.size() != 0)
         @(negedge clock);
      // a trailing non-final row may still be moving through the block
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic set_node_count(input logic [CFG_W-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= NODE_COUNT_ADDR;
      csr_pwdata  <= CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== CSR_DATA_W'(value))
         report_mismatch($sformatf("node_count readback %0h, wrote %0h", csr_prdata, value));
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      node_count_reg = value;
   endtask

   // request driver
   always @(negedge clock) begin : drive_rows
      row_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fired) begin
         if (req_gap > 0) begin
            req_gap   <= req_gap - 1;
            req_valid <= 1'b0;
         end else if (row_q.size() > 0) begin
            nxt = row_q.pop_front();
            req_row_bits <= nxt.bits;
            req_last_row <= nxt.last;
            req_valid    <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) req_gap <= $urandom_range(1, 3);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response stall: short random bursts, plus the long hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (rsp_long_hold) begin
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always begin
      @(freeze_rsp);
      rsp_long_hold = 1'b1;
      repeat (RSP_FREEZE_CYCLES) @(posedge clock);
      rsp_long_hold = 1'b0;
   end

   // request acceptance feeds the predictor; each result is checked against the oldest step
   always @(posedge clock) begin : watch_ports
      cycle_step_type got;
      cycle_step_type want;
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            load_row(req_row_bits, req_last_row);
            rows_accepted++;
         end
         if (rsp_valid && !rsp_stall) begin
            got = '{rsp_node_index, rsp_cycle_end, rsp_single_tour, rsp_last_item};
            if (cycle_steps_q.size() == 0) begin
               report_mismatch($sformatf("result with none pending: node %0d", got.node));
            end else begin
               want = cycle_steps_q.pop_front();
               results_checked++;
               if (got.node !== want.node)
                  report_mismatch($sformatf("node_index %0d, want %0d", got.node, want.node));
               if (got.closes !== want.closes)
                  report_mismatch($sformatf("cycle_end %b, want %b", got.closes, want.closes));
               if (got.one_cycle !== want.one_cycle)
                  report_mismatch($sformatf("single_tour %b, want %b",
                                            got.one_cycle, want.one_cycle));
               if (got.final_step !== want.final_step)
                  report_mismatch($sformatf("last_item %b, want %b",
                                            got.final_step, want.final_step));
            end
         end
      end
   end

   always @(posedge clock) begin
      bench_cycles <= bench_cycles + 1;
      if (bench_cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", bench_cycles);
         $display("FAILURE");
         $finish;
      end
   end

   initial begin : run_phases
      int phase;
      int nprob;
      int directed_rows;
      logic [CFG_W-1:0] cnt_value;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // one node, zero count
      set_node_count(6'd0);
      @(posedge clock);
      queue_row(32'h0000_0000, 1'b1);

      // all-ones row, empty row, then a walk that ends short of its start
      set_node_count(6'd2);
      @(posedge clock);
      queue_row(32'hFFFF_FFFF, 1'b0);
      queue_row(32'h0000_0000, 1'b1);
      queue_row(32'h0000_0002, 1'b0);
      queue_row(32'hFFFF_FFFC, 1'b1);

      // load successors, then shrink the count so they fall out of range
      set_node_count(6'd8);
      @(posedge clock);
      queue_row(32'h0000_0040, 1'b0);
      queue_row(32'h0000_0080, 1'b0);
      queue_row(32'h0000_0020, 1'b0);
      set_node_count(6'd3);
      @(posedge clock);
      queue_row(32'h0000_0001, 1'b1);
      // single row against older entries
      queue_row(32'h0000_0004, 1'b1);

      // four-node tour, top bit set outside range
      set_node_count(6'd4);
      @(posedge clock);
      queue_row(32'h0000_0004, 1'b0);
      queue_row(32'h0000_0008, 1'b0);
      queue_row(32'h0000_0002, 1'b0);
      queue_row(32'h8000_0001, 1'b1);

      directed_rows = rows_pushed;
      phase = 0;
      while (rows_pushed < directed_rows + BASE_ROWS) begin
         cnt_value = (phase == 2) ? 6'd6 : pick_node_count();
         if (rows_pushed >= directed_rows + BASE_ROWS * 4 / 5) calm = 1'b1;
         set_node_count(cnt_value);
         @(posedge clock);
         if (phase == 2) begin
            // receiver holds off while rows keep coming
            -> freeze_rsp;
            nprob = 5;
         end else if (eff_nodes(cnt_value) > 16) begin
            nprob = 1;
         end else begin
            nprob = $urandom_range(1, 3);
         end
         repeat (nprob) queue_problem(pick_shape());
         phase++;
      end

      wait_idle();
      if (cycle_steps_q.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", cycle_steps_q.size()));
      $display("Ran %0d problems over %0d rows: tours, permutations, random maps,",
               problems_sent, rows_pushed);
      $display("short and over-long loads, counts 0 to 63; %0d results checked, %0d mismatches",
               results_checked, mismatches);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

[sim.f]
sv/pcs_pkg.sv
sv/pcs_front.sv
sv/pcs_fifo.sv
sv/pcs_back.sv
sv/permutation_cycle_sorter.sv
bench/tb_top.sv
